[src/affine_span_texture_mapper_assert.svh]
// Assertion macros for the affine span texture mapper.
// No dependencies; included by the top level.
`ifndef AFFINE_SPAN_TEXTURE_MAPPER_ASSERT_SVH
`define AFFINE_SPAN_TEXTURE_MAPPER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASTM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/astm_pkg.sv]
// Shared types and constants for the affine span texture mapper.
// No dependencies.
`timescale 1ns / 1ps

package astm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int TEXEL_DEPTH = 4096;
    localparam int LIGHT_DEPTH = 256;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 10;
    localparam int IN_TDATA_W  = 184;
    localparam int OUT_TDATA_W = 32;
    localparam int CMD_W       = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_TEXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_LIGHT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STEP       = 2'd3;

    // Per-pixel side information that travels with a texel read.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] row;
        logic               done;
        logic               low;
    } t_pix_info;

endpackage

[src/affine_span_texture_mapper.sv]
// Top level of the affine span texture mapper: stream ports, tile and light RAMs.
// Depends on astm_pkg, astm_ram, astm_span, astm_out and the assertion header.
//
// Usage:
//   s_axis carries commands: tuser selects load texel, load light map entry,
//   start span or step one pixel; tdata carries the operands. m_axis carries
//   pixels (color, column, row); tlast marks the final pixel of a span.
//   i_cfg_we/i_cfg_wdata write the low-detail bit; write it only while idle.
// Pipeline: a step transaction reads the tile at input accept; when the
//   tile-read stage advances, it reads the light map and loads the output
//   register, which offers the pixel on m_axis; a stall holds it in the stage.
// Throughput: one transaction per cycle unless stalled; a low-detail step
//   gives two output transactions and holds the output register for both.
// Stall: the output register and the tile-read stage decouple the sides, so
//   s_axis keeps accepting until both hold work that m_axis has not taken.
// Reset: synchronous, active low; clears span state and pipeline valids.
//   Tile and light map contents are undefined until loaded.
`timescale 1ns / 1ps
`include "affine_span_texture_mapper_assert.svh"

module affine_span_texture_mapper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata, low bit up: load_index[11:0], load_value[19:12], span_row[29:20],
    // span_x_first[39:30], span_x_last[49:40], u_start[81:50], v_start[113:82],
    // u_increment[145:114], v_increment[177:146], zero pad[183:178]
    input  logic [astm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser: command[1:0]
    input  logic [astm_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata, low bit up: pixel_color[7:0], screen_x[18:8], screen_y[28:19],
    // zero pad[31:29]
    output logic [astm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tlast: span_done
    output logic                                m_axis_tlast
);
    import astm_pkg::*;

    logic                r_low_detail;
    logic                in_acc;
    logic                pixel;
    t_pix_info           pix_info;
    logic [11:0]         texel_addr;
    logic [COLOR_W-1:0]  texel_data;
    logic [COLOR_W-1:0]  light_data;
    logic                tex_we, light_we, light_re;
    logic                s2_free, s1_go;

    // Tile-read stage.
    logic                r_s1_valid;
    logic                r_s1_pix;
    logic                r_s1_light;
    logic [7:0]          r_s1_lidx;
    logic [COLOR_W-1:0]  r_s1_lval;
    t_pix_info           r_s1_info;

    logic [COLOR_W-1:0]  pixel_color;
    logic [10:0]         screen_x;
    logic [COORD_W-1:0]  screen_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_detail <= 1'b0;
        end else if (i_cfg_we) begin
            r_low_detail <= i_cfg_wdata;
        end
    end

    // Advance the tile-read stage unless it holds a pixel the output cannot take.
    assign s1_go         = r_s1_valid && (!r_s1_pix || s2_free);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    astm_span u_span (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_acc),
        .i_command      (s_axis_tuser),
        .i_span_row     (s_axis_tdata[29:20]),
        .i_span_x_first (s_axis_tdata[39:30]),
        .i_span_x_last  (s_axis_tdata[49:40]),
        .i_u_start      (s_axis_tdata[81:50]),
        .i_v_start      (s_axis_tdata[113:82]),
        .i_u_increment  (s_axis_tdata[145:114]),
        .i_v_increment  (s_axis_tdata[177:146]),
        .i_low_detail   (r_low_detail),
        .o_pixel        (pixel),
        .o_info         (pix_info),
        .o_texel_addr   (texel_addr)
    );

    // Tile writes and reads both happen at input accept, so they stay in order.
    assign tex_we = in_acc && (s_axis_tuser == CMD_LOAD_TEXEL);

    astm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (TEXEL_DEPTH)
    ) u_texel_ram (
        .i_clk   (i_clk),
        .i_we    (tex_we),
        .i_waddr (s_axis_tdata[11:0]),
        .i_wdata (s_axis_tdata[19:12]),
        .i_re    (pixel),
        .i_raddr (texel_addr),
        .o_rdata (texel_data)
    );

    // Light map loads ride the tile-read stage so they stay ordered with
    // the light map reads of earlier steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_pix   <= 1'b0;
            r_s1_light <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= pixel || (s_axis_tuser == CMD_LOAD_LIGHT);
            r_s1_pix   <= pixel;
            r_s1_light <= (s_axis_tuser == CMD_LOAD_LIGHT);
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
            r_s1_pix   <= 1'b0;
            r_s1_light <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_lidx <= s_axis_tdata[7:0];
            r_s1_lval <= s_axis_tdata[19:12];
            r_s1_info <= pix_info;
        end
    end

    assign light_we = s1_go && r_s1_light;
    assign light_re = s1_go && r_s1_pix;

    astm_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (LIGHT_DEPTH)
    ) u_light_ram (
        .i_clk   (i_clk),
        .i_we    (light_we),
        .i_waddr (r_s1_lidx),
        .i_wdata (r_s1_lval),
        .i_re    (light_re),
        .i_raddr (texel_data),
        .o_rdata (light_data)
    );

    astm_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (light_re),
        .i_info        (r_s1_info),
        .i_color       (light_data),
        .o_free        (s2_free),
        .o_tvalid      (m_axis_tvalid),
        .i_tready      (m_axis_tready),
        .o_pixel_color (pixel_color),
        .o_screen_x    (screen_x),
        .o_screen_y    (screen_y),
        .o_span_done   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, screen_y, screen_x, pixel_color};

    // A pixel must never overwrite an output result that is still pending.
    `ASTM_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, light_re, s2_free,
        "pixel entered output stage while it was busy")
    // A pixel moved into the output stage is offered on the next cycle.
    `ASTM_ASSERT_NEXT(a_out_follows, i_clk, i_rst_n, light_re, m_axis_tvalid,
        "output not valid after pixel load")
    // The tile-read stage carries either a light load or a pixel, never both.
    `ASTM_ASSERT_NOW(a_light_excl, i_clk, i_rst_n, r_s1_valid, !(r_s1_pix && r_s1_light),
        "tile-read stage holds both a light load and a pixel")

endmodule

[src/astm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module astm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a read at the write address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/astm_span.sv]
// Span state: row, x range, u/v accumulators and steps; texel address.
// Depends on astm_pkg.
`timescale 1ns / 1ps

module astm_span (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [astm_pkg::CMD_W-1:0]       i_command,
    input  logic [astm_pkg::COORD_W-1:0]     i_span_row,
    input  logic [astm_pkg::COORD_W-1:0]     i_span_x_first,
    input  logic [astm_pkg::COORD_W-1:0]     i_span_x_last,
    input  logic [31:0]                      i_u_start,
    input  logic [31:0]                      i_v_start,
    input  logic [31:0]                      i_u_increment,
    input  logic [31:0]                      i_v_increment,
    input  logic                             i_low_detail,
    output logic                             o_pixel,
    output astm_pkg::t_pix_info              o_info,
    output logic [11:0]                      o_texel_addr
);
    import astm_pkg::*;

    logic [COORD_W-1:0] r_x, n_x;
    logic [COORD_W-1:0] r_final, n_final;
    logic [COORD_W-1:0] r_row, n_row;
    logic [31:0]        r_u, n_u, r_v, n_v, r_du, n_du, r_dv, n_dv;
    logic               r_active, n_active;
    logic               start, done;
    logic [COORD_W-1:0] last_sat, row_sat;

    assign start   = i_accept && (i_command == CMD_START);
    assign o_pixel = i_accept && (i_command == CMD_STEP) && r_active;
    assign done    = (r_x == r_final);

    // Clamp to the screen.
    assign last_sat = ({3'b000, i_span_x_last} > 13'(MAX_WIDTH - 1))
                    ? COORD_W'(MAX_WIDTH - 1) : i_span_x_last;
    assign row_sat  = ({3'b000, i_span_row} > 13'(MAX_HEIGHT - 1))
                    ? COORD_W'(MAX_HEIGHT - 1) : i_span_row;

    always_comb begin
        n_x      = r_x;
        n_final  = r_final;
        n_row    = r_row;
        n_u      = r_u;
        n_v      = r_v;
        n_du     = r_du;
        n_dv     = r_dv;
        n_active = r_active;
        if (start) begin
            n_x      = i_span_x_first;
            n_final  = last_sat;
            n_row    = row_sat;
            n_u      = i_u_start;
            n_v      = i_v_start;
            n_du     = i_u_increment;
            n_dv     = i_v_increment;
            n_active = (i_span_x_first <= last_sat);
        end else if (o_pixel) begin
            n_u = r_u + r_du;
            n_v = r_v + r_dv;
            if (done) begin
                n_active = 1'b0;
            end else begin
                n_x = r_x + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_final  <= '0;
            r_row    <= '0;
            r_u      <= '0;
            r_v      <= '0;
            r_du     <= '0;
            r_dv     <= '0;
            r_active <= 1'b0;
        end else begin
            r_x      <= n_x;
            r_final  <= n_final;
            r_row    <= n_row;
            r_u      <= n_u;
            r_v      <= n_v;
            r_du     <= n_du;
            r_dv     <= n_dv;
            r_active <= n_active;
        end
    end

    // Texel index: v integer bits 5..0 as row, u integer bits 5..0 as column.
    assign o_texel_addr = {r_v[21:16], r_u[21:16]};

    assign o_info.x    = r_x;
    assign o_info.row  = r_row;
    assign o_info.done = done;
    assign o_info.low  = i_low_detail;

endmodule

[src/astm_out.sv]
// Output register: holds one pixel result, emits it once or as a pair.
// Depends on astm_pkg.
`timescale 1ns / 1ps

module astm_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  astm_pkg::t_pix_info              i_info,
    input  logic [astm_pkg::COLOR_W-1:0]     i_color,
    output logic                             o_free,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [astm_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic [10:0]                      o_screen_x,
    output logic [astm_pkg::COORD_W-1:0]     o_screen_y,
    output logic                             o_span_done
);
    import astm_pkg::*;

    logic      r_valid;
    logic      r_beat;
    t_pix_info r_info;
    logic      last_beat;
    logic      take;

    assign last_beat = !r_info.low || r_beat;
    assign take      = r_valid && i_tready;
    assign o_free    = !r_valid || (take && last_beat);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_beat  <= 1'b0;
        end else if (take && last_beat) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_beat <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= i_info;
        end
    end

    assign o_tvalid      = r_valid;
    assign o_pixel_color = i_color;
    assign o_screen_x    = r_info.low ? {r_info.x, r_beat} : {1'b0, r_info.x};
    assign o_screen_y    = r_info.row;
    assign o_span_done   = r_info.done && last_beat;

endmodule

[tb/affine_span_texture_mapper_test.sv]
// Self-checking testbench for affine_span_texture_mapper: directed corner spans, then random
// span sequences under sender gaps, receiver stalls and one long output hold-off.
// Depends on astm_pkg and the affine_span_texture_mapper RTL.
`timescale 1ns / 1ps

module affine_span_texture_mapper_test;
    import astm_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int RANDOM_ITEMS   = 1600;
    // Pipeline is the tile-read stage plus the output register; allow a margin.
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 320;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT    = 50;

    // One command transaction as the block sees it, field by field.
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [11:0]      index;
        logic [7:0]       value;
        logic [9:0]       row;
        logic [9:0]       x_first;
        logic [9:0]       x_last;
        logic [31:0]      u0;
        logic [31:0]      v0;
        logic [31:0]      du;
        logic [31:0]      dv;
    } t_span_cmd;

    // One drawn pixel.
    typedef struct packed {
        logic [7:0]  color;
        logic [10:0] x;
        logic [9:0]  y;
        logic        done;
    } t_pixel;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_wdata   = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    affine_span_texture_mapper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Span renderer model: its own copy of the tile, light map and span state
    // ------------------------------------------------------------------
    logic [7:0]  tile_mem    [TEXEL_DEPTH];
    bit          tile_known  [TEXEL_DEPTH];
    logic [7:0]  light_mem   [LIGHT_DEPTH];
    bit          light_known [LIGHT_DEPTH];
    logic [31:0] u_acc   = '0;
    logic [31:0] v_acc   = '0;
    logic [31:0] u_stp   = '0;
    logic [31:0] v_stp   = '0;
    logic [9:0]  cur_x   = '0;
    logic [9:0]  last_x  = '0;
    logic [9:0]  row_reg = '0;
    bit          drawing  = 1'b0;
    bit          low_mode = 1'b0;

    t_pixel pending_pixels[$];

    int  error_count   = 0;
    int  useful_items  = 0;
    int  burst_left    = 0;
    int  quiet_cycles  = 0;
    bit  sender_eager  = 1'b0;
    bit  hold_request  = 1'b0;
    bit  hold_taken    = 1'b0;
    int  hold_left     = 0;
    bit [31:0] cycle_count = '0;

    // Texel address: v bits 21..16 pick the tile row, u bits 21..16 the column.
    function automatic logic [11:0] tile_address(logic [31:0] u, logic [31:0] v);
        return {v[21:16], u[21:16]};
    endfunction

    // Apply one accepted command and queue the pixels it draws.
    function automatic void render_command(t_span_cmd c);
        logic [11:0] spot;
        logic [7:0]  color;
        logic [9:0]  clip_last;
        logic [9:0]  clip_row;
        bit          done;
        case (c.cmd)
            CMD_LOAD_TEXEL: begin
                tile_mem[c.index]   = c.value;
                tile_known[c.index] = 1'b1;
            end
            CMD_LOAD_LIGHT: begin
                // only the low byte of the index reaches the light map
                light_mem[c.index[7:0]]   = c.value;
                light_known[c.index[7:0]] = 1'b1;
            end
            CMD_START: begin
                clip_last = c.x_last;
                clip_row  = c.row;
                if (clip_last > MAX_WIDTH - 1) clip_last = 10'(MAX_WIDTH - 1);
                if (clip_row > MAX_HEIGHT - 1) clip_row = 10'(MAX_HEIGHT - 1);
                row_reg = clip_row;
                cur_x   = c.x_first;
                last_x  = clip_last;
                u_acc   = c.u0;
                v_acc   = c.v0;
                u_stp   = c.du;
                v_stp   = c.dv;
                // inverted range: empty span
                drawing = (c.x_first <= clip_last);
            end
            default: begin
                if (drawing) begin
                    spot  = tile_address(u_acc, v_acc);
                    color = light_mem[tile_mem[spot]];
                    done  = (cur_x == last_x);
                    if (low_mode) begin
                        // pair at 2x and 2x+1, only the second closes the span
                        pending_pixels.push_back({color, cur_x, 1'b0, row_reg, 1'b0});
                        pending_pixels.push_back({color, cur_x, 1'b1, row_reg, done});
                    end else begin
                        pending_pixels.push_back({color, 1'b0, cur_x, row_reg, done});
                    end
                    u_acc = u_acc + u_stp;
                    v_acc = v_acc + v_stp;
                    if (done) drawing = 1'b0;
                    else cur_x = cur_x + 10'd1;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic t_span_cmd random_command(logic [CMD_W-1:0] cmd);
        t_span_cmd c;
        c.cmd     = cmd;
        c.index   = 12'($urandom);
        c.value   = 8'($urandom);
        c.row     = 10'($urandom);
        c.x_first = 10'($urandom);
        c.x_last  = 10'($urandom);
        c.u0      = $urandom;
        c.v0      = $urandom;
        c.du      = $urandom;
        c.dv      = $urandom;
        return c;
    endfunction

    // Offer one command transaction and hold it until accepted. Bursts of random
    // length alternate with random gaps, unless the sender is set eager.
    task automatic send_command(t_span_cmd c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0 || sender_eager) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        // a step outside a span is ignored by the block: do not count it
        if (!(c.cmd == CMD_STEP && !drawing)) useful_items++;
        s_axis_tuser  <= c.cmd;
        s_axis_tdata  <= {6'd0, c.dv, c.du, c.v0, c.u0, c.x_last, c.x_first, c.row,
                          c.value, c.index};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        render_command(c);
    endtask

    task automatic load_texel(logic [11:0] addr, logic [7:0] val);
        t_span_cmd c;
        c = random_command(CMD_LOAD_TEXEL);
        c.index = addr;
        c.value = val;
        send_command(c);
    endtask

    task automatic load_light(logic [11:0] addr, logic [7:0] val);
        t_span_cmd c;
        c = random_command(CMD_LOAD_LIGHT);
        c.index = addr;
        c.value = val;
        send_command(c);
    endtask

    task automatic start_span(logic [9:0] row, logic [9:0] first, logic [9:0] last,
                              logic [31:0] u0, logic [31:0] v0,
                              logic [31:0] du, logic [31:0] dv);
        t_span_cmd c;
        c = random_command(CMD_START);
        c.row     = row;
        c.x_first = first;
        c.x_last  = last;
        c.u0      = u0;
        c.v0      = v0;
        c.du      = du;
        c.dv      = dv;
        send_command(c);
    endtask

    // Step one pixel. Fill the texel and light entry it reads first if they
    // were never loaded, so that no undefined entry is ever read.
    task automatic draw_step();
        logic [11:0] spot;
        logic [3:0]  high_bits;
        t_span_cmd   c;
        if (drawing) begin
            spot      = tile_address(u_acc, v_acc);
            high_bits = 4'($urandom);
            if (!tile_known[spot]) load_texel(spot, 8'($urandom));
            if (!light_known[tile_mem[spot]])
                load_light({high_bits, tile_mem[spot]}, 8'($urandom));
        end
        c = random_command(CMD_STEP);
        send_command(c);
    endtask

    task automatic random_load();
        if ($urandom_range(0, 1) == 0) load_texel(12'($urandom), 8'($urandom));
        else load_light(12'($urandom), 8'($urandom));
    endtask

    function automatic logic [31:0] random_increment();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        if (r < 80) return $urandom;
        if (r < 87) return 32'h0000_0000;
        if (r < 94) return 32'h0001_0000;
        return 32'hFFFF_0000;
    endfunction

    // Drop valid, wait for every queued pixel, then let the pipeline run dry.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_low_detail(bit val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        low_mode = val;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall pattern changes with bits 8..7 of the cycle counter; a hold-off
    // request forces tready low for a long stretch.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_request && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (cycle_count[8:7])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= cycle_count[3];
            endcase
        end
    end

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("%0t: pixel mismatch on %s: got %0h, want %0h", $time, field, got, want);
        error_count++;
    endtask

    // Compare each output transaction against the oldest queued pixel.
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("unexpected pixel", m_axis_tdata, '0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.color)
                    report_mismatch("pixel_color", 32'(m_axis_tdata[7:0]), 32'(want.color));
                if (m_axis_tdata[18:8] !== want.x)
                    report_mismatch("screen_x", 32'(m_axis_tdata[18:8]), 32'(want.x));
                if (m_axis_tdata[28:19] !== want.y)
                    report_mismatch("screen_y", 32'(m_axis_tdata[28:19]), 32'(want.y));
                if (m_axis_tlast !== want.done)
                    report_mismatch("span_done", 32'(m_axis_tlast), 32'(want.done));
                if (m_axis_tdata[31:29] !== 3'd0)
                    report_mismatch("pad bits", 32'(m_axis_tdata[31:29]), 32'd0);
            end
        end
    end

    // End the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[affine_span_texture_mapper] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_extremes();
        write_low_detail(1'b0);
        load_light(12'hFFF, 8'hA5);     // index above 255 lands on entry 255
        load_light(12'h000, 8'h00);
        load_texel(12'hFFF, 8'hFF);
        load_texel(12'h000, 8'h00);
        // last row, last columns; u and v select the far tile corner, u walks back
        start_span(10'd1023, 10'd1022, 10'd1023, 32'h003F_0000, 32'h003F_FFFF,
                   32'hFFFF_0000, 32'h0000_0000);
        draw_step();
        draw_step();
        draw_step();                    // span closed: no pixel
        start_span(10'd5, 10'd9, 10'd8, 32'h0, 32'h0, 32'h0, 32'h0);  // inverted range
        draw_step();
        // extreme accumulators and steps, then a restart in the middle of the span
        start_span(10'd0, 10'd0, 10'd3, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000);
        draw_step();
        draw_step();
        start_span(10'd512, 10'd10, 10'd10, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0001_0000, 32'hFFFF_FFFF);
        draw_step();
        start_span(10'd0, 10'd0, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0);
        draw_step();
    endtask

    task automatic test_low_detail_pairs();
        write_low_detail(1'b1);
        // last column doubles to 2046 and 2047
        start_span(10'd7, 10'd1023, 10'd1023, $urandom, $urandom, $urandom, $urandom);
        draw_step();
        start_span(10'd300, 10'd0, 10'd2, $urandom, $urandom, random_increment(),
                   random_increment());
        repeat (3) draw_step();
        draw_step();                    // no span: no pair
    endtask

    // Hold the receiver off while the sender streams steps without gaps,
    // so the pipeline fills and s_axis_tready drops.
    task automatic test_output_holdoff();
        write_low_detail(1'b1);
        sender_eager = 1'b1;
        hold_request = 1'b1;
        start_span(10'd99, 10'd100, 10'd179, $urandom, $urandom, random_increment(),
                   random_increment());
        repeat (80) draw_step();
        sender_eager = 1'b0;
    endtask

    // Mostly complete spans with random content; some cut short by a new
    // start, some followed by stray steps, with loads mixed in.
    task automatic random_span();
        int          len;
        int          n_steps;
        int          r;
        logic [9:0]  first;
        logic [9:0]  last;
        logic [31:0] u0;
        logic [31:0] v0;
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 8);
        else if (r < 90) len = $urandom_range(9, 64);
        else if (r < 95) len = $urandom_range(65, 300);
        else len = 0;
        if (len == 0) begin
            first = 10'($urandom_range(1, 1023));
            last  = 10'($urandom_range(0, first - 1));
        end else begin
            first = 10'(($urandom_range(0, 9) == 0) ? 1024 - len
                                                     : $urandom_range(0, 1024 - len));
            last  = 10'(first + len - 1);
        end
        u0 = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h003F_FFFF);
        v0 = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 32'h003F_FFFF);
        start_span(10'($urandom_range(0, 1023)), first, last, u0, v0,
                   random_increment(), random_increment());
        r = $urandom_range(0, 99);
        n_steps = len;
        if (r < 10) n_steps = $urandom_range(0, len);
        else if (r < 20) n_steps = len + $urandom_range(1, 3);
        repeat (n_steps) begin
            if ($urandom_range(0, 19) == 0) random_load();
            draw_step();
        end
    endtask

    // Four phases, the low-detail bit alternating between them.
    task automatic test_random_spans();
        int phase;
        int r;
        for (phase = 0; phase < 4; phase++) begin
            write_low_detail(phase[0]);
            useful_items = 0;
            while (useful_items < RANDOM_ITEMS / 4) begin
                r = $urandom_range(0, 99);
                if (r < 85) random_span();
                else if (r < 95) random_load();
                else draw_step();
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_extremes();
        test_low_detail_pairs();
        test_output_holdoff();
        test_random_spans();
        settle();
        if (error_count == 0)
            $display("[affine_span_texture_mapper] OK");
        else
            $display("[affine_span_texture_mapper] ERROR");
        $finish;
    end

endmodule
